### sv/ready_queue_policy_picker_defines.svh
// assertion macros for the ready queue policy picker
`ifndef READY_QUEUE_POLICY_PICKER_DEFINES_SVH
`define READY_QUEUE_POLICY_PICKER_DEFINES_SVH
// concurrent assertion with reset disable
`define RQP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

### sv/rqpp_pkg.sv
// package with shared types and constants of the ready queue policy picker
package rqpp_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = 5;

  localparam logic [2:0] PolRr  = 3'd0;
  localparam logic [2:0] PolSjf = 3'd1;
  localparam logic [2:0] PolSrt = 3'd2;
  localparam logic [2:0] PolGr  = 3'd3;
  localparam logic [2:0] PolFb  = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic ModeIns  = 1'b0;
  localparam logic ModePick = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] target;
    logic [15:0] served;
    logic [15:0] prio;
  } entry_t;
endpackage

### sv/ready_queue_policy_picker.sv
// top level of the ready queue policy picker
// insert or empty pick: the accept goes to S_OUT, which raises the result valid
// pick of n entries: S_SCAN over slots 1 to n-1, then S_SHIFT closes up from the winner's
// slot to the tail, then S_OUT; the guaranteed policy adds an S_MUL2 multiply step per candidate
// one item at a time; the shared compare/multiply unit sets the scan length,
// and the next item is taken no earlier than the cycle after the result is taken
// rst_ni asynchronous low clears table count, policy, state and valid
module ready_queue_policy_picker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [7:0]            task_id_i,
  input  logic [15:0]           target_time_i,
  input  logic [15:0]           served_time_i,
  input  logic signed [15:0]    task_priority_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [7:0]            picked_id_o,
  output logic [15:0]           picked_target_o,
  output logic [15:0]           picked_served_o,
  output logic signed [15:0]    picked_priority_o,
  output logic [4:0]            occupancy_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_policy_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MUL2, S_CMP, S_SHIFT, S_OUT
  } state_e;

  // table storage: flops, read at the scan index, the slot after it and slot 0
  rqpp_pkg::entry_t slot_q [rqpp_pkg::TableDepth];

  state_e                      state_q;
  logic [2:0]                  policy_q;
  logic [rqpp_pkg::CntW-1:0]   fill_q;
  logic [rqpp_pkg::IdxW-1:0]   idx_q;     // candidate being scanned
  logic [rqpp_pkg::IdxW-1:0]   best_q;
  rqpp_pkg::entry_t            best_e_q;  // copy of best entry
  logic [31:0]                 prod_q;    // served_i * target_best
  logic                        out_valid_q;
  logic [1:0]                  status_q;
  rqpp_pkg::entry_t            res_q;

  rqpp_pkg::entry_t cand;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic        beats;
  logic signed [16:0] rem_c, rem_b;
  logic        last_cand;
  logic        in_acc;

  assign cand = slot_q[idx_q];
  assign in_acc = in_valid_i && !in_stall_o;

  // one shared multiplier: first served_i*target_b, then served_b*target_i
  always_comb begin
    if (state_q == S_SCAN) begin
      mul_a = cand.served;
      mul_b = best_e_q.target;
    end else begin
      mul_a = best_e_q.served;
      mul_b = cand.target;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign rem_c = $signed({1'b0, cand.target}) - $signed({1'b0, cand.served});
  assign rem_b = $signed({1'b0, best_e_q.target}) - $signed({1'b0, best_e_q.served});

  always_comb begin
    case (policy_q)
      rqpp_pkg::PolSjf: beats = cand.target < best_e_q.target;
      rqpp_pkg::PolSrt: beats = rem_c < rem_b;
      rqpp_pkg::PolGr:  beats = prod_q < mul_p;
      rqpp_pkg::PolFb:  beats = $signed(cand.prio) > $signed(best_e_q.prio);
      default:          beats = 1'b0;
    endcase
  end

  assign last_cand = ({1'b0, idx_q} + 5'd1) >= fill_q;

  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o          = status_q;
  assign picked_id_o       = res_q.id;
  assign picked_target_o   = res_q.target;
  assign picked_served_o   = res_q.served;
  assign picked_priority_o = $signed(res_q.prio);
  assign occupancy_o       = fill_q;

  // payload: table entries, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc && mode_i == rqpp_pkg::ModeIns &&
        fill_q < 5'(rqpp_pkg::TableDepth)) begin
      slot_q[fill_q[rqpp_pkg::IdxW-1:0]] <= '{task_id_i, target_time_i,
                                               served_time_i, task_priority_i};
    end else if (state_q == S_SHIFT && !last_cand) begin
      slot_q[idx_q] <= slot_q[idx_q + 1'b1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= rqpp_pkg::PolRr;
      fill_q      <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      best_e_q    <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= rqpp_pkg::StOk;
      res_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i && cfg_ready_o) policy_q <= cfg_policy_i;
          if (in_acc) begin
            res_q <= '0;
            if (mode_i == rqpp_pkg::ModeIns) begin
              if (fill_q >= 5'(rqpp_pkg::TableDepth)) begin
                status_q <= rqpp_pkg::StFull;
              end else begin
                status_q <= rqpp_pkg::StOk;
                fill_q   <= fill_q + 5'd1;
              end
              state_q <= S_OUT;
            end else if (fill_q == '0) begin
              status_q <= rqpp_pkg::StEmpty;
              state_q  <= S_OUT;
            end else begin
              status_q <= rqpp_pkg::StOk;
              best_q   <= '0;
              best_e_q <= slot_q[0];
              // start scan at slot 1; single entry goes straight to close-up
              if (fill_q == 5'd1) begin
                idx_q   <= '0;
                state_q <= S_SHIFT;
              end else begin
                idx_q   <= {{(rqpp_pkg::IdxW-1){1'b0}}, 1'b1};
                state_q <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (policy_q == rqpp_pkg::PolGr) begin
            prod_q  <= mul_p;
            state_q <= S_MUL2;
          end else begin
            if (beats) begin
              best_q   <= idx_q;
              best_e_q <= cand;
            end
            if (last_cand) begin
              state_q <= S_SHIFT;
              idx_q   <= beats ? idx_q : best_q;
            end else begin
              state_q <= S_SCAN;
              idx_q   <= idx_q + 1'b1;
            end
          end
        end
        S_MUL2, S_CMP: begin
          if (beats) begin
            best_q   <= idx_q;
            best_e_q <= cand;
          end
          if (last_cand) begin
            state_q <= S_SHIFT;
            idx_q   <= beats ? idx_q : best_q;
          end else begin
            state_q <= S_SCAN;
            idx_q   <= idx_q + 1'b1;
          end
        end
        S_SHIFT: begin
          // close up one slot per cycle from best to the tail
          if (last_cand) begin
            res_q   <= best_e_q;
            fill_q  <= fill_q - 5'd1;
            state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/rqpp_checker.sv
// port-level checker for the ready queue policy picker
`include "ready_queue_policy_picker_defines.svh"
module rqpp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [4:0] occupancy_o,
  input logic       cfg_ready_o
);
  `RQP_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o), "result dropped while stalled")
  `RQP_ASSERT(a_busy_no_cfg, clk_i, rst_ni, in_stall_o |-> !cfg_ready_o, "config open while busy")
  `RQP_ASSERT(a_occ_range, clk_i, rst_ni, occupancy_o <= 5'd16, "occupancy above depth")
  `RQP_ASSERT(a_status_code, clk_i, rst_ni, out_valid_o |-> status_o != 2'd3, "bad status code")
endmodule

bind ready_queue_policy_picker rqpp_checker u_rqpp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o),
  .occupancy_o(occupancy_o), .cfg_ready_o(cfg_ready_o)
);
